// ===== rtl/tcce_pkg.sv =====
// ----------------------------------------------------------------------------
// tcce_pkg - text console cursor engine shared definitions
// Screen geometry, derived widths, character codes and cell constants.
// ----------------------------------------------------------------------------
package tcce_pkg;

   // screen geometry
   localparam int COLS   = 80;
   localparam int ROWS   = 25;
   localparam int CELLS  = ROWS * COLS;

   // derived widths
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLS + 1);   // holds COLS for a pending wrap
   localparam int ADDR_W = $clog2(CELLS);

   // fixed field widths
   localparam int CELL_W  = 16;
   localparam int CHAR_W  = 8;
   localparam int ATTR_W  = 8;
   localparam int INDEX_W = 11;
   localparam int OROW_W  = 5;
   localparam int OCOL_W  = 7;

   // character codes with a meaning
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
   localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

   // cursor constants
   localparam int TAB_STOP  = 4;
   localparam int QUIRK_COL = 8;

   // attribute after reset
   localparam logic [ATTR_W-1:0] RESET_ATTR = 8'd31;

   // function codes
   localparam logic FUNC_PUT  = 1'b0;
   localparam logic FUNC_READ = 1'b1;

endpackage

// ===== rtl/tcce_ram.sv =====
// ----------------------------------------------------------------------------
// tcce_ram - generic single-clock RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tcce_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/text_console_cursor_engine.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_engine - text console with cursor and scrolling screen
// A small sequencer drives one screen RAM port pair to interpret characters,
// scroll the screen and read back cells.
// ----------------------------------------------------------------------------
// Sequence: a read is issued, then its data returned; a return or a backspace at
//   home ends after decode; other put words go on to a cell write, a tab fill or
//   the new-line step; a deferred wrap adds the new-line step and a scroll copies
//   every row up, then blanks the bottom row. One word at a time; busy drops in
//   the cycle the result shows. Reset: cursor home, attribute 31, then a clearing
//   pass of all CELLS cells (2000 by default), busy high. The receiver cannot stall.
module text_console_cursor_engine (
   input  logic                          clock,
   input  logic                          reset,
   // command channel
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_func,
   input  logic [tcce_pkg::CHAR_W-1:0]   req_char_code,
   input  logic [tcce_pkg::INDEX_W-1:0]  req_cell_index,
   // result channel
   output logic                          rsp_strobe,
   output logic [tcce_pkg::CELL_W-1:0]   rsp_cell_value,
   output logic [tcce_pkg::OROW_W-1:0]   rsp_cursor_row,
   output logic [tcce_pkg::OCOL_W-1:0]   rsp_cursor_col,
   // configuration
   input  logic                          csr_wr_en,
   input  logic [tcce_pkg::ATTR_W-1:0]   csr_wr_data
);

   localparam int ROW_W  = tcce_pkg::ROW_W;
   localparam int COL_W  = tcce_pkg::COL_W;
   localparam int ADDR_W = tcce_pkg::ADDR_W;
   localparam int CELL_W = tcce_pkg::CELL_W;

   // backspace quirk applies only when the cell after it lies in the row
   localparam bit QUIRK_OK = (tcce_pkg::QUIRK_COL + 1) < tcce_pkg::COLS;

   // sequencer states
   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_DECODE   = 4'd2;
   localparam logic [3:0] S_POST     = 4'd3;
   localparam logic [3:0] S_PUT      = 4'd4;
   localparam logic [3:0] S_TAB      = 4'd5;
   localparam logic [3:0] S_CELL_WR  = 4'd6;
   localparam logic [3:0] S_SCROLL   = 4'd7;
   localparam logic [3:0] S_DRAIN    = 4'd8;
   localparam logic [3:0] S_BLANK    = 4'd9;
   localparam logic [3:0] S_RD_ISSUE = 4'd10;
   localparam logic [3:0] S_RD_DATA  = 4'd11;
   localparam logic [3:0] S_DONE     = 4'd12;

   // control state
   logic [3:0]                      state_ff, state_in;
   logic [ROW_W-1:0]                row_ff, row_in;
   logic [COL_W-1:0]                col_ff, col_in;
   logic [ADDR_W-1:0]               scan_ff, scan_in;
   logic                            cp_valid_ff, cp_valid_in;
   logic [tcce_pkg::ATTR_W-1:0]     attr_ff, attr_in;
   logic                            rsp_strobe_ff, rsp_strobe_in;

   // payload registers
   logic [tcce_pkg::CHAR_W-1:0]     char_ff, char_in;
   logic [tcce_pkg::INDEX_W-1:0]    idx_ff, idx_in;
   logic [ADDR_W-1:0]               cp_addr_ff, cp_addr_in;
   logic [CELL_W-1:0]               rsp_value_ff, rsp_value_in;
   logic [ROW_W-1:0]                rsp_row_ff, rsp_row_in;
   logic [COL_W-1:0]                rsp_col_ff, rsp_col_in;

   // RAM port
   logic                            wr_en;
   logic [ADDR_W-1:0]               wr_addr;
   logic [CELL_W-1:0]               wr_data;
   logic                            rd_en;
   logic [ADDR_W-1:0]               rd_addr;
   logic [CELL_W-1:0]               rd_data;

   // helpers
   logic                            accept;
   logic [ADDR_W-1:0]               cur_addr;
   logic [CELL_W-1:0]               blank_cell;
   logic [COL_W-1:0]                col_nx;
   logic                            idx_in_range;

   assign accept       = start && (state_ff == S_IDLE);
   assign busy         = (state_ff != S_IDLE);
   assign cur_addr     = ADDR_W'(row_ff) * ADDR_W'(tcce_pkg::COLS) + ADDR_W'(col_ff);
   assign blank_cell   = {attr_ff, tcce_pkg::CH_BLANK};
   assign col_nx       = col_ff + COL_W'(1);
   assign idx_in_range = int'(idx_ff) < tcce_pkg::CELLS;

   // screen store
   tcce_ram #(
      .WIDTH (CELL_W),
      .DEPTH (tcce_pkg::CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // RAM write selection: a pending scroll copy goes first
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cur_addr;
      wr_data = blank_cell;
      if (cp_valid_ff) begin
         wr_en   = 1'b1;
         wr_addr = cp_addr_ff;
         wr_data = rd_data;
      end else begin
         unique case (state_ff) inside
            S_CLEAR: begin
               wr_en   = 1'b1;
               wr_addr = scan_ff;
               wr_data = {tcce_pkg::RESET_ATTR, tcce_pkg::CH_BLANK};
            end
            S_BLANK: begin
               wr_en   = 1'b1;
               wr_addr = scan_ff;
            end
            S_PUT: begin
               wr_en   = 1'b1;
               wr_data = {attr_ff, char_ff};
            end
            S_TAB, S_CELL_WR: begin
               wr_en   = 1'b1;
            end
            default: begin
               wr_en   = 1'b0;
            end
         endcase
      end
   end

   // RAM read selection
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = scan_ff;
      unique case (state_ff)
         S_SCROLL: begin
            rd_en = 1'b1;
         end
         S_RD_ISSUE: begin
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(idx_ff);
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      scan_in       = scan_ff;
      cp_valid_in   = 1'b0;
      cp_addr_in    = scan_ff - ADDR_W'(tcce_pkg::COLS);
      attr_in       = csr_wr_en ? csr_wr_data : attr_ff;
      char_in       = char_ff;
      idx_in        = idx_ff;
      rsp_strobe_in = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;

      unique case (state_ff)
         // clear the store after reset
         S_CLEAR: begin
            scan_in = scan_ff + ADDR_W'(1);
            if (scan_ff == ADDR_W'(tcce_pkg::CELLS - 1)) begin
               state_in = S_IDLE;
            end
         end

         // take a word
         S_IDLE: begin
            if (accept) begin
               char_in  = req_char_code;
               idx_in   = req_cell_index;
               state_in = (req_func == tcce_pkg::FUNC_READ) ? S_RD_ISSUE : S_DECODE;
            end
         end

         // interpret the character
         S_DECODE: begin
            if ((char_ff == tcce_pkg::CH_NEWLINE) ||
                (((char_ff != tcce_pkg::CH_RETURN) && (char_ff != tcce_pkg::CH_BACKSPACE))
                 && (col_ff >= COL_W'(tcce_pkg::COLS)))) begin
               // new line, possibly by scrolling
               if (row_ff < ROW_W'(tcce_pkg::ROWS - 1)) begin
                  row_in   = row_ff + ROW_W'(1);
                  col_in   = '0;
                  state_in = S_POST;
               end else begin
                  scan_in  = ADDR_W'(tcce_pkg::COLS);
                  state_in = S_SCROLL;
               end
            end else if (char_ff == tcce_pkg::CH_RETURN) begin
               col_in   = '0;
               state_in = S_DONE;
            end else if (char_ff == tcce_pkg::CH_BACKSPACE) begin
               if (QUIRK_OK && (col_ff == COL_W'(tcce_pkg::QUIRK_COL))) begin
                  col_in   = COL_W'(tcce_pkg::QUIRK_COL + 1);
                  state_in = S_CELL_WR;
               end else if ((col_ff == '0) && (row_ff == '0)) begin
                  state_in = S_DONE;
               end else if (col_ff == '0) begin
                  row_in   = row_ff - ROW_W'(1);
                  col_in   = COL_W'(tcce_pkg::COLS - 1);
                  state_in = S_CELL_WR;
               end else begin
                  col_in   = col_ff - COL_W'(1);
                  state_in = S_CELL_WR;
               end
            end else if (char_ff == tcce_pkg::CH_TAB) begin
               state_in = S_TAB;
            end else begin
               state_in = S_PUT;
            end
         end

         // continue after a new line
         S_POST: begin
            if (char_ff == tcce_pkg::CH_NEWLINE) begin
               state_in = S_DONE;
            end else if (char_ff == tcce_pkg::CH_TAB) begin
               state_in = S_TAB;
            end else begin
               state_in = S_PUT;
            end
         end

         // character written at the cursor
         S_PUT: begin
            col_in   = col_nx;
            state_in = S_DONE;
         end

         // tab fill, one blank a cycle
         S_TAB: begin
            col_in = col_nx;
            if (((col_nx % COL_W'(tcce_pkg::TAB_STOP)) == '0) ||
                (col_nx == COL_W'(tcce_pkg::COLS))) begin
               state_in = S_DONE;
            end
         end

         // backspace blank
         S_CELL_WR: begin
            state_in = S_DONE;
         end

         // scroll: copy one cell up a row each cycle
         S_SCROLL: begin
            cp_valid_in = 1'b1;
            scan_in     = scan_ff + ADDR_W'(1);
            if (scan_ff == ADDR_W'(tcce_pkg::CELLS - 1)) begin
               state_in = S_DRAIN;
            end
         end

         // last copy lands
         S_DRAIN: begin
            scan_in  = ADDR_W'(tcce_pkg::CELLS - tcce_pkg::COLS);
            state_in = S_BLANK;
         end

         // blank the last row
         S_BLANK: begin
            scan_in = scan_ff + ADDR_W'(1);
            if (scan_ff == ADDR_W'(tcce_pkg::CELLS - 1)) begin
               col_in   = '0;
               state_in = S_POST;
            end
         end

         // cell read
         S_RD_ISSUE: begin
            state_in = S_RD_DATA;
         end

         S_RD_DATA: begin
            rsp_strobe_in = 1'b1;
            rsp_value_in  = idx_in_range ? rd_data : '0;
            rsp_row_in    = row_ff;
            rsp_col_in    = col_ff;
            state_in      = S_IDLE;
         end

         // put result
         S_DONE: begin
            rsp_strobe_in = 1'b1;
            rsp_value_in  = '0;
            rsp_row_in    = row_ff;
            rsp_col_in    = col_ff;
            state_in      = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         row_ff        <= '0;
         col_ff        <= '0;
         scan_ff       <= '0;
         cp_valid_ff   <= 1'b0;
         attr_ff       <= tcce_pkg::RESET_ATTR;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         scan_ff       <= scan_in;
         cp_valid_ff   <= cp_valid_in;
         attr_ff       <= attr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      char_ff      <= char_in;
      idx_ff       <= idx_in;
      cp_addr_ff   <= cp_addr_in;
      rsp_value_ff <= rsp_value_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
   end

   // result word
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_cell_value = rsp_value_ff;
   assign rsp_cursor_row = tcce_pkg::OROW_W'(rsp_row_ff);
   assign rsp_cursor_col = tcce_pkg::OCOL_W'(rsp_col_ff);

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - text console cursor engine regression
// Drives put and read words through the command channel at random pace and
// checks each result strobe against a screen and cursor predictor kept in a
// small scoreboard. The colour attribute is changed between phases.
// ----------------------------------------------------------------------------
module testbench;
   import tcce_pkg::*;

   localparam int WORDS_TARGET = 1050;
   localparam int MAX_SHOWN    = 10;
   // slowest legal run: every word a full scroll plus the longest gap, kept 4x
   localparam int LIMIT_CYCLES = 4 * (1250 * (CELLS + 64) + CELLS + 1000);

   typedef struct packed {
      logic [CELL_W-1:0] value;
      logic [OROW_W-1:0] row;
      logic [OCOL_W-1:0] col;
   } console_result_type;

   // screen and cursor predictor with the queue of results still owed
   class console_scoreboard;
      logic [CELL_W-1:0]  screen [CELLS];
      int                 row;
      int                 col;
      logic [ATTR_W-1:0]  attr;
      console_result_type owed_results[$];
      int                 failures;

      function new();
         row  = 0;
         col  = 0;
         attr = RESET_ATTR;
         failures = 0;
         foreach (screen[i]) screen[i] = {RESET_ATTR, CH_BLANK};
      endfunction

      function logic [CELL_W-1:0] blank_cell();
         return {attr, CH_BLANK};
      endfunction

      function void store(int c, logic [CELL_W-1:0] v);
         if (row < ROWS && c < COLS) screen[row * COLS + c] = v;
      endfunction

      // next row, or scroll rows 1.. up and blank the bottom one
      function void line_feed();
         if (row < ROWS - 1) begin
            row++;
         end else begin
            for (int i = COLS; i < CELLS; i++) screen[i - COLS] = screen[i];
            for (int i = 0; i < COLS; i++) screen[(ROWS - 1) * COLS + i] = blank_cell();
         end
         col = 0;
      endfunction

      // note an accepted word and work out the result it owes
      function void take_word(logic f, logic [CHAR_W-1:0] ch, logic [INDEX_W-1:0] idx);
         console_result_type r;
         int                 n;
         r.value = '0;
         if (f == FUNC_READ) begin
            if (idx < CELLS) r.value = screen[idx];
         end else if (ch == CH_NEWLINE) begin
            line_feed();
         end else if (ch == CH_RETURN) begin
            col = 0;
         end else if (ch == CH_BACKSPACE) begin
            if (col == QUIRK_COL && QUIRK_COL + 1 < COLS) begin
               // odd forward step kept from the original console
               col = QUIRK_COL + 1;
               store(col, blank_cell());
            end else if (col != 0 || row != 0) begin
               if (col == 0) begin
                  row--;
                  col = COLS;
               end
               col--;
               store(col, blank_cell());
            end
         end else if (ch == CH_TAB) begin
            if (col >= COLS) line_feed();
            n = TAB_STOP - (col % TAB_STOP);
            while (n != 0 && col < COLS) begin
               store(col, blank_cell());
               col++;
               n--;
            end
         end else begin
            // deferred wrap taken before the write
            if (col >= COLS) line_feed();
            store(col, {attr, ch});
            col++;
         end
         r.row = row[OROW_W-1:0];
         r.col = col[OCOL_W-1:0];
         owed_results.push_back(r);
      endfunction

      function void fail_note(string msg);
         failures++;
         if (failures <= MAX_SHOWN) $display("%t: %s", $realtime, msg);
      endfunction

      // compare one strobed result with the oldest one owed
      function void check_word(logic [CELL_W-1:0] got_value, logic [OROW_W-1:0] r_row,
                               logic [OCOL_W-1:0] r_col);
         console_result_type e;
         if (owed_results.size() == 0) begin
            fail_note($sformatf("unexpected result cell %h row %0d col %0d",
                                got_value, r_row, r_col));
            return;
         end
         e = owed_results.pop_front();
         if (got_value !== e.value || r_row !== e.row || r_col !== e.col)
            fail_note($sformatf({"mismatch: expected cell %h row %0d col %0d,",
                                 " got cell %h row %0d col %0d"},
                                e.value, e.row, e.col, got_value, r_row, r_col));
      endfunction

      function void close_out();
         if (owed_results.size() != 0)
            fail_note($sformatf("%0d results never arrived", owed_results.size()));
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_func;
   logic [CHAR_W-1:0]   req_char_code;
   logic [INDEX_W-1:0]  req_cell_index;
   logic                rsp_strobe;
   logic [CELL_W-1:0]   rsp_cell_value;
   logic [OROW_W-1:0]   rsp_cursor_row;
   logic [OCOL_W-1:0]   rsp_cursor_col;
   logic                csr_wr_en;
   logic [ATTR_W-1:0]   csr_wr_data;

   console_scoreboard sb;
   int                words_sent;
   int                cycles;
   bit                no_gaps;

   text_console_cursor_engine dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_char_code  (req_char_code),
      .req_cell_index (req_cell_index),
      .rsp_strobe     (rsp_strobe),
      .rsp_cell_value (rsp_cell_value),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1)
         sb.check_word(rsp_cell_value, rsp_cursor_row, rsp_cursor_col);
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("text_console_cursor_engine regression: fail");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   task automatic idle_gap();
      int r;
      int n;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 50) n = 0;
      else if (r < 90) n = $urandom_range(1, 3);
      else n = $urandom_range(10, 40);
      if (n > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic send_word(input logic f, input logic [CHAR_W-1:0] ch,
                            input logic [INDEX_W-1:0] idx);
      @(negedge clock);
      start          <= 1'b1;
      req_func       <= f;
      req_char_code  <= ch;
      req_cell_index <= idx;
      do @(posedge clock); while (busy !== 1'b0);
      sb.take_word(f, ch, idx);
      words_sent++;
      idle_gap();
   endtask

   task automatic put_char(input logic [CHAR_W-1:0] ch);
      send_word(FUNC_PUT, ch, INDEX_W'($urandom_range(0, 2047)));
   endtask

   task automatic read_cell(input int idx);
      send_word(FUNC_READ, CHAR_W'($urandom_range(0, 255)), INDEX_W'(idx));
   endtask

   // attribute change once the engine has gone quiet
   task automatic write_attr(input logic [ATTR_W-1:0] a);
      @(negedge clock);
      start <= 1'b0;
      while (sb.owed_results.size() != 0 || busy !== 1'b0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= a;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.attr = a;
   endtask

   // one random burst: text lines most often, the rest edits, reads and noise
   task automatic random_burst();
      int r;
      int len;
      int idx;
      r = $urandom_range(0, 99);
      if (r < 35) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(70, 100) : $urandom_range(1, 20);
         repeat (len) begin
            if ($urandom_range(0, 7) == 0) put_char(CHAR_W'($urandom_range(0, 255)));
            else put_char(CHAR_W'($urandom_range(32, 126)));
         end
         case ($urandom_range(0, 4))
            0: put_char(CH_NEWLINE);
            1: begin
               put_char(CH_RETURN);
               put_char(CH_NEWLINE);
            end
            2: put_char(CH_TAB);
            default: begin
            end
         endcase
      end else if (r < 48) begin
         repeat ($urandom_range(1, 12)) put_char(CH_BACKSPACE);
      end else if (r < 56) begin
         repeat ($urandom_range(1, 3)) put_char(CH_TAB);
      end else if (r < 64) begin
         repeat ($urandom_range(1, 4)) put_char(CH_NEWLINE);
      end else if (r < 67) begin
         put_char(CH_RETURN);
      end else if (r < 85) begin
         // reads near the cursor, anywhere, or around the end of the screen
         case ($urandom_range(0, 2))
            0: idx = sb.row * COLS + $urandom_range(0, COLS - 1);
            1: idx = $urandom_range(0, 2047);
            default: idx = $urandom_range(CELLS - COLS, 2047);
         endcase
         read_cell(idx);
      end else begin
         send_word(1'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)),
                   INDEX_W'($urandom_range(0, 2047)));
      end
   endtask

   initial begin
      sb             = new();
      words_sent     = 0;
      cycles         = 0;
      no_gaps        = 1'b0;
      reset          = 1'b1;
      start          = 1'b0;
      req_func       = FUNC_PUT;
      req_char_code  = '0;
      req_cell_index = '0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // directed: reset contents, range edges, every control byte
      read_cell(0);
      read_cell(CELLS - 1);
      read_cell(CELLS);
      read_cell(2047);
      put_char(CH_BACKSPACE);          // at home: no effect
      put_char(8'h41);
      put_char(8'h00);
      put_char(8'hFF);
      put_char(CH_TAB);                // column 3 to 4
      repeat (4) put_char(8'h78);      // column 8
      put_char(CH_BACKSPACE);          // quirk: steps forward to 9
      read_cell(QUIRK_COL + 1);
      put_char(CH_RETURN);
      put_char(CH_NEWLINE);
      put_char(CH_BACKSPACE);          // wraps back to the end of row 0
      read_cell(COLS - 1);
      put_char(CH_NEWLINE);
      put_char(CH_TAB);
      read_cell(COLS);

      // random phases, attribute extremes first
      write_attr(8'h00);
      while (words_sent < 300) random_burst();
      write_attr(8'hFF);
      no_gaps = 1'b1;
      while (words_sent < 550) random_burst();
      no_gaps = 1'b0;
      write_attr(ATTR_W'($urandom_range(0, 255)));
      while (words_sent < 800) random_burst();
      write_attr(ATTR_W'($urandom_range(0, 255)));
      while (words_sent < WORDS_TARGET) random_burst();

      // drain
      @(negedge clock);
      start <= 1'b0;
      while (sb.owed_results.size() != 0) @(posedge clock);
      repeat (CELLS + 16) @(posedge clock);
      sb.close_out();
      if (sb.failures == 0)
         $display("text_console_cursor_engine regression: pass");
      else
         $display("text_console_cursor_engine regression: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/tcce_pkg.sv
rtl/tcce_ram.sv
rtl/text_console_cursor_engine.sv
dv/testbench.sv
